/* hdl/qoa_pkg.sv */
`default_nettype none

package qoa_pkg;

   localparam int QOA_MAX_CHANNELS = 8;
   localparam int MAX_SLICE        = 20;
   localparam int TAPS             = 4;
   localparam int BUF_DEPTH        = 2 * MAX_SLICE;
   localparam int BUF_AW           = $clog2(BUF_DEPTH);

   typedef logic signed [15:0] smp_type;

   typedef struct packed {
      logic                 buf_sel;
      logic [4:0]           len;
      logic [2:0]           chan;
      logic                 frame_first;
      smp_type [TAPS-1:0]   first;
   } job_type;

   typedef struct packed {
      logic       buf_sel;
      logic [4:0] idx;
   } rd_req_type;

   typedef struct packed {
      logic valid;
      logic buf_sel;
   } release_type;

   typedef struct packed {
      smp_type [TAPS-1:0] h;
      smp_type [TAPS-1:0] w;
      logic [3:0]         sf;
   } chst_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_LOAD,
      BK_TINIT,
      BK_S0,
      BK_S1,
      BK_S2,
      BK_S3,
      BK_TEND,
      BK_TCMP,
      BK_FIN
   } bk_state_type;

   function automatic logic [2:0] quant_code(input logic [4:0] idx);
      logic [2:0] q;
      unique case (idx)
         5'd0, 5'd1, 5'd2:    q = 3'd7;
         5'd3, 5'd4:          q = 3'd5;
         5'd5, 5'd6:          q = 3'd3;
         5'd7:                q = 3'd1;
         5'd8, 5'd9:          q = 3'd0;
         5'd10, 5'd11:        q = 3'd2;
         5'd12, 5'd13:        q = 3'd4;
         5'd14, 5'd15, 5'd16: q = 3'd6;
         default:             q = 3'd0;
      endcase
      return q;
   endfunction

   function automatic logic [16:0] recip(input logic [3:0] sf);
      logic [16:0] r;
      unique case (sf)
         4'd0:  r = 17'd65536;
         4'd1:  r = 17'd9363;
         4'd2:  r = 17'd3121;
         4'd3:  r = 17'd1457;
         4'd4:  r = 17'd781;
         4'd5:  r = 17'd475;
         4'd6:  r = 17'd311;
         4'd7:  r = 17'd216;
         4'd8:  r = 17'd156;
         4'd9:  r = 17'd117;
         4'd10: r = 17'd90;
         4'd11: r = 17'd71;
         4'd12: r = 17'd57;
         4'd13: r = 17'd47;
         4'd14: r = 17'd39;
         default: r = 17'd32;
      endcase
      return r;
   endfunction

   function automatic logic [13:0] dq_mag(input logic [3:0] sf, input logic [1:0] lvl);
      logic [55:0] row;
      unique case (sf)
         4'd0:  row = {14'd7,     14'd5,    14'd3,    14'd1};
         4'd1:  row = {14'd49,    14'd32,   14'd18,   14'd5};
         4'd2:  row = {14'd147,   14'd95,   14'd53,   14'd16};
         4'd3:  row = {14'd315,   14'd203,  14'd113,  14'd34};
         4'd4:  row = {14'd588,   14'd378,  14'd210,  14'd63};
         4'd5:  row = {14'd966,   14'd621,  14'd345,  14'd104};
         4'd6:  row = {14'd1477,  14'd950,  14'd528,  14'd158};
         4'd7:  row = {14'd2128,  14'd1368, 14'd760,  14'd228};
         4'd8:  row = {14'd2947,  14'd1895, 14'd1053, 14'd316};
         4'd9:  row = {14'd3934,  14'd2529, 14'd1405, 14'd422};
         4'd10: row = {14'd5117,  14'd3290, 14'd1828, 14'd548};
         4'd11: row = {14'd6496,  14'd4176, 14'd2320, 14'd696};
         4'd12: row = {14'd8099,  14'd5207, 14'd2893, 14'd868};
         4'd13: row = {14'd9933,  14'd6386, 14'd3548, 14'd1064};
         4'd14: row = {14'd12005, 14'd7718, 14'd4288, 14'd1286};
         default: row = {14'd14336, 14'd9216, 14'd5120, 14'd1536};
      endcase
      return row[lvl*14 +: 14];
   endfunction

endpackage

`default_nettype wire

/* hdl/qoa_slice_encoder.sv */
`default_nettype none

// channel  | direction | handshake         | payload
// req_     | in        | req_valid/stall   | sample, channel, frame flag, end of slice
// rsp_     | out       | rsp_valid/stall   | slice word, channel, lms history and weights
//
// each item is taken while the slice buffer being filled is free; two buffers
// the search engine runs one trial per scalefactor, with an lms step per sample in each;
// early stop on a losing trial shortens that trial
// synchronous reset clears buffer occupancy, queue and channel-started state
// rsp_stall holds the result register; the engine waits only when a second result is ready

module qoa_slice_encoder import qoa_pkg::*; #(
   parameter int MAX_CHANNELS = QOA_MAX_CHANNELS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_sample,
   input  wire logic [2:0]  req_channel,
   input  wire logic        req_frame_first_slice,
   input  wire logic        req_last_in_slice,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_slice_word,
   output logic [2:0]       rsp_slice_channel,
   output logic [15:0]      rsp_history_0,
   output logic [15:0]      rsp_history_1,
   output logic [15:0]      rsp_history_2,
   output logic [15:0]      rsp_history_3,
   output logic [15:0]      rsp_weight_0,
   output logic [15:0]      rsp_weight_1,
   output logic [15:0]      rsp_weight_2,
   output logic [15:0]      rsp_weight_3
);

   logic        push_valid, job_valid, job_pop;
   job_type     push_job, head;
   rd_req_type  rd_req;
   smp_type     rd_data;
   release_type rel;

   qoa_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_sample            (req_sample),
      .req_channel           (req_channel),
      .req_frame_first_slice (req_frame_first_slice),
      .req_last_in_slice     (req_last_in_slice),
      .push_valid            (push_valid),
      .push_job              (push_job),
      .rd_req                (rd_req),
      .rd_data               (rd_data),
      .rel                   (rel)
   );

   qoa_jobq u_jobq (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_job  (push_job),
      .pop       (job_pop),
      .not_empty (job_valid),
      .head      (head)
   );

   qoa_back #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (job_valid),
      .job               (head),
      .job_pop           (job_pop),
      .rd_req            (rd_req),
      .rd_data           (rd_data),
      .rel               (rel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_slice_word    (rsp_slice_word),
      .rsp_slice_channel (rsp_slice_channel),
      .rsp_history_0     (rsp_history_0),
      .rsp_history_1     (rsp_history_1),
      .rsp_history_2     (rsp_history_2),
      .rsp_history_3     (rsp_history_3),
      .rsp_weight_0      (rsp_weight_0),
      .rsp_weight_1      (rsp_weight_1),
      .rsp_weight_2      (rsp_weight_2),
      .rsp_weight_3      (rsp_weight_3)
   );

endmodule

`default_nettype wire

/* hdl/qoa_front.sv */
`default_nettype none

module qoa_front import qoa_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire smp_type     req_sample,
   input  wire logic [2:0]  req_channel,
   input  wire logic        req_frame_first_slice,
   input  wire logic        req_last_in_slice,
   output logic             push_valid,
   output job_type          push_job,
   input  wire rd_req_type  rd_req,
   output smp_type          rd_data,
   input  wire release_type rel
);

   logic [4:0]         cnt_ff, cnt_in;
   logic               wsel_ff, wsel_in;
   logic [1:0]         busy_ff, busy_in;
   logic [2:0]         chan_ff;
   logic               ffl_ff;
   smp_type [TAPS-1:0] first_ff, first_in;
   smp_type            sbuf [BUF_DEPTH];
   smp_type            rd_data_ff;
   logic               accept, closing;
   logic [BUF_AW-1:0]  waddr, raddr;

   assign req_stall = busy_ff[wsel_ff];
   assign accept    = req_valid & ~req_stall;
   assign closing   = req_last_in_slice | (cnt_ff == 5'(MAX_SLICE - 1));
   assign waddr     = BUF_AW'(wsel_ff) * BUF_AW'(MAX_SLICE) + BUF_AW'(cnt_ff);
   assign raddr     = BUF_AW'(rd_req.buf_sel) * BUF_AW'(MAX_SLICE) + BUF_AW'(rd_req.idx);
   assign rd_data   = rd_data_ff;

   always_comb begin
      first_in = (cnt_ff == 5'd0) ? '0 : first_ff;
      if (cnt_ff < 5'd4) begin
         first_in[cnt_ff[1:0]] = req_sample;
      end
   end

   assign push_valid            = accept & closing;
   assign push_job.buf_sel      = wsel_ff;
   assign push_job.len          = cnt_ff + 5'd1;
   assign push_job.chan         = (cnt_ff == 5'd0) ? req_channel : chan_ff;
   assign push_job.frame_first  = (cnt_ff == 5'd0) ? req_frame_first_slice : ffl_ff;
   assign push_job.first        = first_in;

   always_comb begin
      cnt_in  = cnt_ff;
      wsel_in = wsel_ff;
      busy_in = busy_ff;
      if (rel.valid) begin
         busy_in[rel.buf_sel] = 1'b0;
      end
      if (accept) begin
         if (closing) begin
            cnt_in           = 5'd0;
            wsel_in          = ~wsel_ff;
            busy_in[wsel_ff] = 1'b1;
         end else begin
            cnt_in = cnt_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         wsel_ff <= 1'b0;
         busy_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         wsel_ff <= wsel_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         first_ff <= first_in;
         if (cnt_ff == 5'd0) begin
            chan_ff <= req_channel;
            ffl_ff  <= req_frame_first_slice;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sbuf[waddr] <= req_sample;
      end
      rd_data_ff <= sbuf[raddr];
   end

endmodule

`default_nettype wire

/* hdl/qoa_jobq.sv */
`default_nettype none

module qoa_jobq import qoa_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output logic         not_empty,
   output job_type      head
);

   job_type    q_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff, cnt_in;

   assign not_empty = (cnt_ff != 2'd0);
   assign head      = q_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (pop) begin
            rp_ff <= ~rp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= push_job;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff != 2'd2 || pop)) else $error("job queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != 2'd0) else $error("job queue underflow");
`endif

endmodule

`default_nettype wire

/* hdl/qoa_back.sv */
`default_nettype none

module qoa_back import qoa_pkg::*; #(
   parameter int MAX_CHANNELS = QOA_MAX_CHANNELS
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       job_valid,
   input  wire job_type    job,
   output logic            job_pop,
   output rd_req_type      rd_req,
   input  wire smp_type    rd_data,
   output release_type     rel,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [63:0]     rsp_slice_word,
   output logic [2:0]      rsp_slice_channel,
   output smp_type         rsp_history_0,
   output smp_type         rsp_history_1,
   output smp_type         rsp_history_2,
   output smp_type         rsp_history_3,
   output smp_type         rsp_weight_0,
   output smp_type         rsp_weight_1,
   output smp_type         rsp_weight_2,
   output smp_type         rsp_weight_3
);

   localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   function automatic logic [CW-1:0] chan_idx(input logic [2:0] c);
      logic [8:0] v;
      v = 9'(c);
      for (int k = 0; k < 8; k++) begin
         if (v >= 9'(MAX_CHANNELS)) begin
            v = v - 9'(MAX_CHANNELS);
         end
      end
      return CW'(v);
   endfunction

   bk_state_type state_ff, state_in;

   job_type                  job_ff;
   logic [CW-1:0]            ci_ff;
   chst_type                 st_mem [MAX_CHANNELS];
   chst_type                 st_rd_ff;
   logic [MAX_CHANNELS-1:0]  started_ff;

   smp_type [TAPS-1:0] base_h_ff, base_w_ff, h_ff, w_ff, best_h_ff, best_w_ff;
   logic [3:0]         sf_ff, trial_ff, best_sf_ff;
   logic [4:0]         idx_ff;
   logic signed [31:0] prod_ff [TAPS];
   logic signed [20:0] pred_ff;
   logic signed [21:0] r_ff;
   smp_type            s_ff;
   logic signed [39:0] m_ff;
   logic [63:0]        word_ff, best_word_ff;
   logic signed [16:0] e_ff;
   logic               e_pend_ff;
   logic [39:0]        err_ff, best_err_ff;
   logic               abort_ff;
   logic               rsp_valid_ff;

   logic               out_free, fin_go, last_smp;
   logic signed [33:0] acc;
   logic signed [20:0] pred_c;
   logic signed [39:0] m_c, v_c;
   logic signed [23:0] nq;
   logic signed [1:0]  sr, sn;
   logic signed [24:0] n2;
   logic [4:0]         qidx;
   logic [2:0]         q;
   logic [13:0]        mag;
   logic signed [15:0] dq, delta16;
   logic signed [21:0] rsum;
   smp_type            rec;
   logic signed [33:0] sq;
   logic [39:0]        err_sum;
   logic [6:0]         pad_sh;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign last_smp = (idx_ff == job_ff.len - 5'd1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:  if (job_valid) state_in = BK_LOAD;
         BK_LOAD:  state_in = BK_TINIT;
         BK_TINIT: state_in = BK_S0;
         BK_S0:    state_in = BK_S1;
         BK_S1:    state_in = BK_S2;
         BK_S2:    state_in = BK_S3;
         BK_S3:    state_in = (last_smp || abort_ff) ? BK_TEND : BK_S0;
         BK_TEND:  state_in = BK_TCMP;
         BK_TCMP:  state_in = (trial_ff == 4'd15) ? BK_FIN : BK_TINIT;
         BK_FIN:   if (out_free) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      job_pop = 1'b0;
      fin_go  = 1'b0;
      unique case (state_ff)
         BK_IDLE: job_pop = job_valid;
         BK_FIN:  fin_go  = out_free;
         default: ;
      endcase
   end

   assign rd_req.buf_sel = job_ff.buf_sel;
   assign rd_req.idx     = idx_ff;
   assign rel.valid      = fin_go;
   assign rel.buf_sel    = job_ff.buf_sel;

   // datapath
   always_comb begin
      acc    = 34'(prod_ff[0]) + 34'(prod_ff[1]) + 34'(prod_ff[2]) + 34'(prod_ff[3]);
      pred_c = 21'(acc >>> 13);
      m_c    = r_ff * $signed({1'b0, recip(sf_ff)});
      v_c    = m_ff + 40'sd32768;
      nq     = v_c[39] ? -24'((-v_c) >>> 16) : 24'(v_c >>> 16);
      sr     = (r_ff > 0) ? 2'sd1 : ((r_ff < 0) ? -2'sd1 : 2'sd0);
      sn     = (nq > 0) ? 2'sd1 : ((nq < 0) ? -2'sd1 : 2'sd0);
      n2     = 25'(nq) + 25'(sr) - 25'(sn);
      if (n2 < -25'sd8) begin
         qidx = 5'd0;
      end else if (n2 > 25'sd8) begin
         qidx = 5'd16;
      end else begin
         qidx = 5'(n2 + 25'sd8);
      end
      q       = quant_code(qidx);
      mag     = dq_mag(sf_ff, q[2:1]);
      dq      = q[0] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
      delta16 = dq >>> 4;
      rsum    = 22'(pred_ff) + 22'(dq);
      if (rsum > 22'sd32767) begin
         rec = 16'sh7fff;
      end else if (rsum < -22'sd32768) begin
         rec = 16'sh8000;
      end else begin
         rec = rsum[15:0];
      end
      sq      = e_ff * e_ff;
      err_sum = err_ff + 40'($unsigned(sq));
      pad_sh  = (7'(MAX_SLICE) - 7'(job_ff.len)) * 7'd3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         started_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         e_pend_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         e_pend_ff <= (state_ff == BK_S3);
         if (fin_go) begin
            started_ff[ci_ff] <= 1'b1;
            rsp_valid_ff      <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fin_go) begin
         st_mem[ci_ff] <= '{h: best_h_ff, w: best_w_ff, sf: best_sf_ff};
      end
      st_rd_ff <= st_mem[chan_idx(job.chan)];
   end

   always_ff @(posedge clock) begin
      if (e_pend_ff) begin
         err_ff <= err_sum;
         if (err_sum > best_err_ff) begin
            abort_ff <= 1'b1;
         end
      end
      unique case (state_ff)
         BK_IDLE: begin
            job_ff <= job;
            ci_ff  <= chan_idx(job.chan);
         end
         BK_LOAD: begin
            best_err_ff  <= '1;
            best_word_ff <= '0;
            best_sf_ff   <= '0;
            best_h_ff    <= '0;
            best_w_ff    <= '0;
            trial_ff     <= '0;
            if (started_ff[ci_ff]) begin
               base_h_ff <= st_rd_ff.h;
               base_w_ff <= st_rd_ff.w;
               sf_ff     <= job_ff.frame_first ? 4'd0 : st_rd_ff.sf;
            end else begin
               base_h_ff <= {job_ff.first[0], job_ff.first[1],
                             job_ff.first[2], job_ff.first[3]};
               base_w_ff <= {16'sh4000, 16'she000, 16'sh0000, 16'sh0000};
               sf_ff     <= 4'd0;
            end
         end
         BK_TINIT: begin
            h_ff     <= base_h_ff;
            w_ff     <= base_w_ff;
            idx_ff   <= '0;
            err_ff   <= '0;
            abort_ff <= 1'b0;
            word_ff  <= 64'(sf_ff);
         end
         BK_S0: begin
            for (int k = 0; k < TAPS; k++) begin
               prod_ff[k] <= $signed(w_ff[k]) * $signed(h_ff[k]);
            end
         end
         BK_S1: begin
            pred_ff <= pred_c;
            s_ff    <= rd_data;
            r_ff    <= 22'($signed(rd_data)) - 22'(pred_c);
         end
         BK_S2: begin
            m_ff <= m_c;
         end
         BK_S3: begin
            e_ff <= 17'(s_ff) - 17'(rec);
            for (int k = 0; k < TAPS; k++) begin
               w_ff[k] <= h_ff[k][15] ? w_ff[k] - delta16 : w_ff[k] + delta16;
            end
            h_ff    <= {rec, h_ff[3], h_ff[2], h_ff[1]};
            word_ff <= {word_ff[60:0], q};
            idx_ff  <= idx_ff + 5'd1;
         end
         BK_TEND: ;
         BK_TCMP: begin
            if (err_ff < best_err_ff) begin
               best_err_ff  <= err_ff;
               best_word_ff <= word_ff;
               best_sf_ff   <= sf_ff;
               best_h_ff    <= h_ff;
               best_w_ff    <= w_ff;
            end
            sf_ff    <= sf_ff + 4'd1;
            trial_ff <= trial_ff + 4'd1;
         end
         BK_FIN: begin
            if (out_free) begin
               rsp_slice_word    <= best_word_ff << pad_sh;
               rsp_slice_channel <= job_ff.chan;
               rsp_history_0     <= best_h_ff[0];
               rsp_history_1     <= best_h_ff[1];
               rsp_history_2     <= best_h_ff[2];
               rsp_history_3     <= best_h_ff[3];
               rsp_weight_0      <= best_w_ff[0];
               rsp_weight_1      <= best_w_ff[1];
               rsp_weight_2      <= best_w_ff[2];
               rsp_weight_3      <= best_w_ff[3];
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_all_trials: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_FIN |-> trial_ff == 4'd0 && $past(trial_ff) != 4'd0 || $past(state_ff) == BK_FIN)
      else $error("slice finished before all scalefactors were tried");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_S0 |-> idx_ff < job_ff.len) else $error("sample index past slice end");
   a_best_set: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_TINIT && trial_ff != 4'd0) |-> best_err_ff != '1)
      else $error("no best trial after first trial");
`endif

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import qoa_pkg::*;

   localparam int ITEM_TARGET = 1700;
   localparam int STALL_LIMIT = 30000;

   typedef struct packed {
      logic [63:0]      word;
      logic [2:0]       chan;
      logic [3:0][15:0] h;
      logic [3:0][15:0] w;
   } slice_res_type;

   typedef struct packed {
      logic [15:0]   smp;
      logic [2:0]    chan;
      logic          ff;
      logic          last;
      logic          known;
      slice_res_type res;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_sample = '0;
   logic [2:0]  req_channel = '0;
   logic        req_frame_first_slice = 1'b0;
   logic        req_last_in_slice = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_slice_word;
   logic [2:0]  rsp_slice_channel;
   logic [15:0] rsp_history_0, rsp_history_1, rsp_history_2, rsp_history_3;
   logic [15:0] rsp_weight_0, rsp_weight_1, rsp_weight_2, rsp_weight_3;

   qoa_slice_encoder uut (.*);

   always #10 clock = ~clock;

   // encoder state as seen by the predictor
   int            slice_buf[MAX_SLICE];
   int            fill_cnt;
   int            load_ch;
   bit            load_ff;
   int            hist[8][4];
   int            wts[8][4];
   int            prev_sf[8];
   bit            started[8];
   slice_res_type pending_slices[$];

   int quant_idx[17] = '{7, 7, 7, 5, 5, 3, 3, 1, 0, 0, 2, 2, 4, 4, 6, 6, 6};
   int recip_val[16] = '{65536, 9363, 3121, 1457, 781, 475, 311, 216, 156, 117, 90, 71,
                         57, 47, 39, 32};
   int dq_step[16][4] = '{
      '{1, 3, 5, 7}, '{5, 18, 32, 49}, '{16, 53, 95, 147}, '{34, 113, 203, 315},
      '{63, 210, 378, 588}, '{104, 345, 621, 966}, '{158, 528, 950, 1477},
      '{228, 760, 1368, 2128}, '{316, 1053, 1895, 2947}, '{422, 1405, 2529, 3934},
      '{548, 1828, 3290, 5117}, '{696, 2320, 4176, 6496}, '{868, 2893, 5207, 8099},
      '{1064, 3548, 6386, 9933}, '{1286, 4288, 7718, 12005}, '{1536, 5120, 9216, 14336}};

   int errors = 0;
   int items_sent = 0;
   int slices_seen = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   logic hold = 1'b0;
   int quiet_cycles = 0;

   function automatic int sgn(longint v);
      return (v > 0) - (v < 0);
   endfunction

   function automatic int quantise(int r, int sf);
      longint n;
      n = (longint'(r) * recip_val[sf] + 32768) / 65536;
      n = n + sgn(r) - sgn(n);
      if (n < -8) n = -8;
      if (n > 8) n = 8;
      return int'(n);
   endfunction

   task automatic predict_item(input logic [15:0] smp, input logic [2:0] chan, input logic ff,
                               input logic last);
      int len, ci, start, sf, best_sf, pred, q, dq, rec, delta, s;
      int h[4], w[4], bh[4], bw[4];
      longint acc, e;
      longint unsigned err, best_err;
      logic [63:0] word, best_word;
      logic [31:0] tmp;
      slice_res_type r;
      if (fill_cnt == 0) begin
         load_ch = chan;
         load_ff = ff;
      end
      slice_buf[fill_cnt] = $signed(smp);
      fill_cnt++;
      if (!last && fill_cnt < MAX_SLICE) return;
      len = fill_cnt;
      fill_cnt = 0;
      ci = load_ch % 8;
      if (!started[ci]) begin
         for (int k = 0; k < 4; k++) hist[ci][3-k] = k < len ? slice_buf[k] : 0;
         wts[ci] = '{0, 0, -8192, 16384};
         started[ci] = 1'b1;
      end
      best_err = '1;
      best_word = '0;
      best_sf = 0;
      bh = '{0, 0, 0, 0};
      bw = '{0, 0, 0, 0};
      start = load_ff ? 0 : prev_sf[ci];
      for (int t = 0; t < 16; t++) begin
         sf = (t + start) & 15;
         word = sf;
         err = 0;
         h = hist[ci];
         w = wts[ci];
         for (int i = 0; i < len; i++) begin
            s = slice_buf[i];
            acc = 0;
            for (int k = 0; k < 4; k++) acc += longint'(w[k]) * h[k];
            pred = int'(acc >>> 13);
            q = quant_idx[quantise(s - pred, sf) + 8];
            dq = q[0] ? -dq_step[sf][q >> 1] : dq_step[sf][q >> 1];
            rec = pred + dq;
            if (rec > 32767) rec = 32767;
            if (rec < -32768) rec = -32768;
            e = s - rec;
            err += longint'(e * e);
            if (err > best_err) break;
            delta = dq >>> 4;
            for (int k = 0; k < 4; k++) begin
               tmp = h[k] < 0 ? w[k] - delta : w[k] + delta;
               w[k] = $signed(tmp[15:0]);
            end
            h = '{h[1], h[2], h[3], rec};
            word = (word << 3) | q;
         end
         if (err < best_err) begin
            best_err = err;
            best_word = word;
            best_sf = sf;
            bh = h;
            bw = w;
         end
      end
      prev_sf[ci] = best_sf;
      hist[ci] = bh;
      wts[ci] = bw;
      r.word = best_word << ((MAX_SLICE - len) * 3);
      r.chan = load_ch[2:0];
      for (int k = 0; k < 4; k++) begin
         r.h[k] = bh[k][15:0];
         r.w[k] = bw[k][15:0];
      end
      pending_slices.push_back(r);
   endtask

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   task automatic check_slice();
      slice_res_type x;
      logic [3:0][15:0] gh, gw;
      gh = {rsp_history_3, rsp_history_2, rsp_history_1, rsp_history_0};
      gw = {rsp_weight_3, rsp_weight_2, rsp_weight_1, rsp_weight_0};
      slices_seen++;
      if (pending_slices.size() == 0) begin
         report("unexpected slice", rsp_slice_word, '0);
         return;
      end
      x = pending_slices.pop_front();
      if (rsp_slice_word !== x.word) report("slice word", rsp_slice_word, x.word);
      if (rsp_slice_channel !== x.chan) report("channel", rsp_slice_channel, x.chan);
      for (int k = 0; k < 4; k++) begin
         if (gh[k] !== x.h[k]) report($sformatf("history_%0d", k), gh[k], x.h[k]);
         if (gw[k] !== x.w[k]) report($sformatf("weight_%0d", k), gw[k], x.w[k]);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_slice();
      rsp_stall <= !reset && (hold || $urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_item(input logic [15:0] smp, input logic [2:0] chan, input logic ff,
                            input logic last, input logic known = 1'b0,
                            input slice_res_type res = '0);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= smp;
      req_channel <= chan;
      req_frame_first_slice <= ff;
      req_last_in_slice <= last;
      do @(posedge clock); while (req_stall);
      predict_item(smp, chan, ff, last);
      if (known) begin
         void'(pending_slices.pop_back());
         pending_slices.push_back(res);
      end
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_slices.size() != 0) @(posedge clock);
   endtask

   task automatic random_slice(input int len);
      logic [2:0] chan;
      logic ff, last;
      int mode, x;
      logic [15:0] smp;
      chan = 3'($urandom_range(0, 7));
      ff = $urandom_range(0, 3) == 0;
      mode = $urandom_range(0, 3);
      x = $urandom_range(0, 65535) - 32768;
      for (int i = 0; i < len; i++) begin
         case (mode)
            0: smp = 16'($urandom);
            1: begin
               x += $urandom_range(0, 4000) - 2000;
               if (x > 32767) x = 32767;
               if (x < -32768) x = -32768;
               smp = x[15:0];
            end
            2: smp = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: smp = 16'($urandom_range(0, 63) - 32);
         endcase
         last = (i == len - 1) && (len < MAX_SLICE || $urandom_range(0, 1));
         if (i == 0)
            send_item(smp, chan, ff, last);
         else
            send_item(smp, 3'($urandom), 1'($urandom), last);
      end
   endtask

   stim_row_type rows[25];
   int phase_idle[4] = '{0, 58, 0, 31};
   int phase_stall[4] = '{0, 0, 58, 31};

   initial begin
      // zero sample, first slice of channel 0: only scalefactor 0 reaches error 1
      rows[0] = '{16'h0000, 3'd0, 1'b1, 1'b1, 1'b1,
                  '{64'h0, 3'd0, {16'h0001, 16'h0, 16'h0, 16'h0},
                    {16'h4000, 16'he000, 16'h0, 16'h0}}};
      rows[1] = '{16'h7fff, 3'd7, 1'b1, 1'b0, 1'b0, '0};
      rows[2] = '{16'h8000, 3'd0, 1'b0, 1'b0, 1'b0, '0};
      rows[3] = '{16'h7fff, 3'd0, 1'b0, 1'b1, 1'b0, '0};
      rows[4] = '{16'h8000, 3'd5, 1'b0, 1'b1, 1'b0, '0};
      for (int i = 5; i < 25; i++)
         rows[i] = '{i[0] ? 16'h8000 : 16'h7fff, i == 5 ? 3'd2 : 3'd5, i == 5 ? 1'b0 : 1'b1,
                     1'b0, 1'b0, '0};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i])
         send_item(rows[i].smp, rows[i].chan, rows[i].ff, rows[i].last, rows[i].known,
                   rows[i].res);
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = phase_idle[ph];
         stall_pct = phase_stall[ph];
         while (items_sent < 25 + ITEM_TARGET * (ph + 1) / 4)
            random_slice($urandom_range(0, 3) == 0 ? $urandom_range(1, 19) : MAX_SLICE);
         drain();
      end
      // long receiver hold-off while items keep coming
      idle_pct = 0;
      stall_pct = 0;
      fork
         begin
            hold <= 1'b1;
            repeat (3000) @(posedge clock);
            hold <= 1'b0;
         end
      join_none
      repeat (4) random_slice(MAX_SLICE);
      drain();
      repeat (200) @(posedge clock);
      $display("%0d items sent, %0d slices checked", items_sent, slices_seen);
      $display("covered: extremes, short and full slices, all channels, idle mixes, hold-off");
      if (errors == 0 && pending_slices.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* qoa_slice_encoder.f */
hdl/qoa_pkg.sv
hdl/qoa_front.sv
hdl/qoa_jobq.sv
hdl/qoa_back.sv
hdl/qoa_slice_encoder.sv
sim/tb_top.sv
